// ----- hdl/scp_pkg.sv -----
// scp_pkg: types, constants and control structs for the serial command line parser
// no dependencies
package scp_pkg;

   localparam int LINE_BYTES = 64;
   localparam int LINE_SLOTS = 8;
   localparam int POS_W = $clog2(LINE_BYTES);
   localparam int SLOT_W = $clog2(LINE_SLOTS);
   localparam int MEM_W = POS_W + SLOT_W;
   localparam int DEPTH_W = 3;
   localparam int DELAY_W = 24;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd100000;
   localparam logic [DELAY_W-1:0] ELAPSED_MAX = '1;
   localparam logic [15:0] COUNT_MAX = 16'hffff;
   localparam logic [POS_W-1:0] LEN_MAX = POS_W'(LINE_BYTES - 1);

   localparam logic [2:0] CMD_CHAR = 3'd0;
   localparam logic [2:0] CMD_TICK = 3'd1;
   localparam logic [2:0] CMD_POLL = 3'd2;
   localparam logic [2:0] CMD_TAKE = 3'd3;
   localparam logic [2:0] CMD_READ = 3'd4;

   localparam logic [2:0] CODE_NONE = 3'd0;
   localparam logic [2:0] CODE_START = 3'd1;
   localparam logic [2:0] CODE_HALT = 3'd2;
   localparam logic [2:0] CODE_RESET = 3'd3;
   localparam logic [2:0] CODE_BATTERY = 3'd4;

   localparam logic [0:0] REG_DELAY = 1'd0;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] char_in;
      logic [6:0] read_limit;
   } req_type;

   typedef struct packed {
      logic        command_ready;
      logic [2:0]  command_code;
      logic        line_valid;
      logic [7:0]  line_char;
      logic        last;
      logic [2:0]  line_depth;
      logic [2:0]  max_line_depth;
      logic [15:0] dropped_lines;
      logic [15:0] dropped_chars;
      logic        shortcut_pending;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECIDE, ST_COPY, ST_READ, ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, apply its work to the datapath state
      logic decide;     // classify submitted line
      logic copy_step;  // copy one char into slot
      logic copy_done;  // finish enqueue
      logic read_start; // dequeue and set up readout
      logic read_step;  // advance readout pointer
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic need_decide;
      logic do_enqueue;
      logic copy_last;
      logic read_go;
      logic read_last;
   } sts_type;

   function automatic logic [1:0] sc_index(input logic [7:0] c);
      case (c)
         8'h73: sc_index = 2'd0;
         8'h68: sc_index = 2'd1;
         8'h72: sc_index = 2'd2;
         default: sc_index = 2'd3;
      endcase
   endfunction

   function automatic logic [7:0] sc_upper(input logic [1:0] l);
      case (l)
         2'd0: sc_upper = 8'h53;
         2'd1: sc_upper = 8'h48;
         2'd2: sc_upper = 8'h52;
         default: sc_upper = 8'h42;
      endcase
   endfunction

endpackage

// ----- hdl/scp_ctrl.sv -----
// scp_ctrl: sequencer for line submit, slot copy and line readout
// depends on scp_pkg
module scp_ctrl import scp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    emit_read
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.need_decide && sts.do_enqueue) state_in = ST_COPY;
            else if (sts.read_go) state_in = ST_READ;
            else state_in = ST_EMIT;
         end
         ST_COPY: begin
            if (sts.copy_last) state_in = ST_EMIT;
         end
         ST_READ: begin
            if (rsp_ready && sts.read_last) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      emit_read = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load = req_valid;
         end
         ST_DECIDE: begin
            ctl.decide = sts.need_decide;
            ctl.read_start = sts.read_go;
         end
         ST_COPY: begin
            ctl.copy_step = 1'b1;
            ctl.copy_done = sts.copy_last;
         end
         ST_READ: begin
            rsp_valid = 1'b1;
            emit_read = 1'b1;
            ctl.read_step = rsp_ready;
         end
         ST_EMIT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY && !sts.copy_last |=> state_ff == ST_COPY)
      else $error("copy left early");

endmodule

// ----- hdl/scp_datapath.sv -----
// scp_datapath: line buffer, shortcut, command register, line queue and counters
// depends on scp_pkg
module scp_datapath import scp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  ctl_type            ctl,
   input  logic               emit_read,
   input  logic [DELAY_W-1:0] delay,
   output sts_type            sts,
   output rsp_type            rsp_data
);

   logic [7:0] line_buf [LINE_BYTES];
   logic [7:0] slot_text [LINE_SLOTS*LINE_BYTES];
   logic [POS_W-1:0] slot_len [LINE_SLOTS];

   logic [POS_W-1:0] line_len_ff, line_len_in;
   logic sc_pending_ff, sc_pending_in;
   logic [1:0] sc_letter_ff, sc_letter_in;
   logic [DELAY_W-1:0] sc_elapsed_ff, sc_elapsed_in;
   logic cmd_ready_ff, cmd_ready_in;
   logic [2:0] cmd_code_ff, cmd_code_in;
   logic [SLOT_W-1:0] q_head_ff, q_head_in, q_tail_ff, q_tail_in;
   logic [DEPTH_W-1:0] q_max_ff, q_max_in;
   logic [15:0] drop_l_ff, drop_l_in, drop_c_ff, drop_c_in;
   logic submit_ff, submit_in;
   logic rdy_ff, rdy_in;
   logic [2:0] code_ff, code_in;
   logic read_go_ff, read_go_in;
   logic [POS_W-1:0] pos_ff, pos_in, rlen_ff, rlen_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [7:0] rd_char_ff;
   logic [7:0] b0_ff, b1_ff, b2_ff, b3_ff, b4_ff;
   logic pend2_ff, pend2_in;
   logic [7:0] pend2_char_ff, pend2_char_in;
   logic cp_we_ff;
   logic [MEM_W-1:0] cp_addr_ff;
   logic [7:0] cp_char_ff;

   logic wr_en;
   logic [POS_W-1:0] wr_pos;
   logic [7:0] wr_char;
   logic [7:0] c, cu;
   logic promo, avail;
   logic [2:0] cls;
   logic [SLOT_W-1:0] next_head;
   logic [DEPTH_W-1:0] depth, depth_after;
   logic [POS_W-1:0] cap, lim_m1;
   logic [6:0] slen_ext;

   assign c = req_data.char_in;
   assign next_head = q_head_ff + SLOT_W'(1);
   assign depth = DEPTH_W'(SLOT_W'(q_head_ff - q_tail_ff));
   assign depth_after = DEPTH_W'(SLOT_W'(next_head - q_tail_ff));
   assign promo = sc_pending_ff && (sc_elapsed_ff >= delay);
   assign avail = cmd_ready_ff || promo;

   // first five chars of the line for command matching
   always_ff @(posedge clock) begin
      if (wr_en && wr_pos == POS_W'(0)) b0_ff <= wr_char;
      if (wr_en && wr_pos == POS_W'(1)) b1_ff <= wr_char;
      if (wr_en && wr_pos == POS_W'(2)) b2_ff <= wr_char;
      if (wr_en && wr_pos == POS_W'(3)) b3_ff <= wr_char;
      if (wr_en && wr_pos == POS_W'(4)) b4_ff <= wr_char;
   end

   always_comb begin
      cls = CODE_NONE;
      if ((line_len_ff == POS_W'(1) && b0_ff == 8'h47) ||
          (line_len_ff == POS_W'(5) && {b0_ff, b1_ff, b2_ff, b3_ff, b4_ff} == "START"))
         cls = CODE_START;
      else if ((line_len_ff == POS_W'(1) && (b0_ff == 8'h48 || b0_ff == 8'h58)) ||
               (line_len_ff == POS_W'(4) && ({b0_ff, b1_ff, b2_ff, b3_ff} == "HALT" ||
                {b0_ff, b1_ff, b2_ff, b3_ff} == "STOP")))
         cls = CODE_HALT;
      else if (line_len_ff == POS_W'(5) && {b0_ff, b1_ff, b2_ff, b3_ff, b4_ff} == "RESET")
         cls = CODE_RESET;
   end

   assign sts.need_decide = submit_ff;
   assign sts.do_enqueue = (line_len_ff != '0) && (cls == CODE_NONE) &&
                           (next_head != q_tail_ff);
   assign sts.copy_last = (pos_ff == line_len_ff - POS_W'(1));
   assign sts.read_go = read_go_ff;
   assign slen_ext = {1'b0, slot_len[q_tail_ff]};
   assign lim_m1 = POS_W'(req_data.read_limit - 7'd1);
   assign cap = (slen_ext >= req_data.read_limit) ? lim_m1 : slot_len[q_tail_ff];
   assign sts.read_last = (pos_ff == rlen_ff - POS_W'(1)) || (rlen_ff == '0);

   always_comb begin
      line_len_in = line_len_ff;
      sc_pending_in = sc_pending_ff;
      sc_letter_in = sc_letter_ff;
      sc_elapsed_in = sc_elapsed_ff;
      cmd_ready_in = cmd_ready_ff;
      cmd_code_in = cmd_code_ff;
      q_head_in = q_head_ff;
      q_tail_in = q_tail_ff;
      q_max_in = q_max_ff;
      drop_l_in = drop_l_ff;
      drop_c_in = drop_c_ff;
      submit_in = 1'b0;
      rdy_in = rdy_ff;
      code_in = code_ff;
      read_go_in = 1'b0;
      pos_in = pos_ff;
      rlen_in = rlen_ff;
      rslot_in = rslot_ff;
      pend2_in = 1'b0;
      pend2_char_in = pend2_char_ff;
      wr_en = 1'b0;
      wr_pos = line_len_ff;
      wr_char = c;
      cu = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
      if (ctl.load) begin
         rdy_in = 1'b0;
         code_in = CODE_NONE;
         pos_in = '0;
         case (req_data.command)
            CMD_CHAR: begin
               if (c == 8'h0a || c == 8'h0d) begin
                  if (sc_pending_ff) begin
                     sc_pending_in = 1'b0;
                     if (line_len_ff == LEN_MAX) begin
                        if (drop_c_ff != COUNT_MAX) drop_c_in = drop_c_ff + 16'd1;
                     end else begin
                        wr_en = 1'b1;
                        wr_char = sc_upper(sc_letter_ff);
                        line_len_in = line_len_ff + POS_W'(1);
                     end
                  end
                  submit_in = 1'b1;
               end else if (c == 8'h08 || c == 8'h7f) begin
                  if (sc_pending_ff) sc_pending_in = 1'b0;
                  else if (line_len_ff != '0) line_len_in = line_len_ff - POS_W'(1);
               end else if (c >= 8'h20 && c <= 8'h7e) begin
                  if (sc_pending_ff) begin
                     // shortcut became text; the char lands at position 1 next cycle
                     sc_pending_in = 1'b0;
                     wr_en = 1'b1;
                     wr_pos = '0;
                     wr_char = sc_upper(sc_letter_ff);
                     line_len_in = POS_W'(1);
                     pend2_in = 1'b1;
                     pend2_char_in = cu;
                  end else if (line_len_ff == '0 &&
                               (c == 8'h73 || c == 8'h68 || c == 8'h72 || c == 8'h62)) begin
                     sc_pending_in = 1'b1;
                     sc_letter_in = sc_index(c);
                     sc_elapsed_in = '0;
                  end else if (line_len_ff == LEN_MAX) begin
                     if (drop_c_ff != COUNT_MAX) drop_c_in = drop_c_ff + 16'd1;
                  end else begin
                     wr_en = 1'b1;
                     wr_char = cu;
                     line_len_in = line_len_ff + POS_W'(1);
                  end
               end
            end
            CMD_TICK: begin
               if (sc_pending_ff && sc_elapsed_ff != ELAPSED_MAX)
                  sc_elapsed_in = sc_elapsed_ff + DELAY_W'(1);
            end
            CMD_POLL, CMD_TAKE: begin
               if (!cmd_ready_ff && promo) begin
                  sc_pending_in = 1'b0;
                  cmd_ready_in = 1'b1;
                  cmd_code_in = 3'(sc_letter_ff) + 3'd1;
               end
               rdy_in = avail;
               code_in = avail ? (cmd_ready_ff ? cmd_code_ff : 3'(sc_letter_ff) + 3'd1)
                               : CODE_NONE;
               if (req_data.command == CMD_TAKE && avail) begin
                  cmd_ready_in = 1'b0;
                  cmd_code_in = CODE_NONE;
               end
            end
            CMD_READ: begin
               if (req_data.read_limit != '0 && depth != '0) begin
                  read_go_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (pend2_ff) begin
         wr_en = 1'b1;
         wr_pos = POS_W'(1);
         wr_char = pend2_char_ff;
         line_len_in = POS_W'(2);
      end
      if (ctl.decide) begin
         if (line_len_ff != '0) begin
            if (cls != CODE_NONE) begin
               if (cmd_ready_ff) begin
                  if (drop_l_ff != COUNT_MAX) drop_l_in = drop_l_ff + 16'd1;
               end else begin
                  cmd_ready_in = 1'b1;
                  cmd_code_in = cls;
               end
               line_len_in = '0;
            end else if (!sts.do_enqueue) begin
               if (drop_l_ff != COUNT_MAX) drop_l_in = drop_l_ff + 16'd1;
               line_len_in = '0;
            end
         end
      end
      if (ctl.copy_step) pos_in = pos_ff + POS_W'(1);
      if (ctl.copy_done) begin
         q_head_in = next_head;
         if (depth_after > q_max_ff) q_max_in = depth_after;
         line_len_in = '0;
         pos_in = '0;
      end
      if (ctl.read_start) begin
         rslot_in = q_tail_ff;
         rlen_in = cap;
         q_tail_in = q_tail_ff + SLOT_W'(1);
         pos_in = '0;
      end
      if (ctl.read_step) pos_in = pos_ff + POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= '0;
         sc_pending_ff <= 1'b0;
         sc_letter_ff <= '0;
         sc_elapsed_ff <= '0;
         cmd_ready_ff <= 1'b0;
         cmd_code_ff <= CODE_NONE;
         q_head_ff <= '0;
         q_tail_ff <= '0;
         q_max_ff <= '0;
         drop_l_ff <= '0;
         drop_c_ff <= '0;
         submit_ff <= 1'b0;
         read_go_ff <= 1'b0;
         pend2_ff <= 1'b0;
         cp_we_ff <= 1'b0;
      end else begin
         line_len_ff <= line_len_in;
         sc_pending_ff <= sc_pending_in;
         sc_letter_ff <= sc_letter_in;
         sc_elapsed_ff <= sc_elapsed_in;
         cmd_ready_ff <= cmd_ready_in;
         cmd_code_ff <= cmd_code_in;
         q_head_ff <= q_head_in;
         q_tail_ff <= q_tail_in;
         q_max_ff <= q_max_in;
         drop_l_ff <= drop_l_in;
         drop_c_ff <= drop_c_in;
         submit_ff <= submit_in;
         read_go_ff <= read_go_in;
         pend2_ff <= pend2_in;
         cp_we_ff <= ctl.copy_step;
      end
   end

   always_ff @(posedge clock) begin
      rdy_ff <= rdy_in;
      code_ff <= code_in;
      pos_ff <= pos_in;
      rlen_ff <= rlen_in;
      rslot_ff <= rslot_in;
      pend2_char_ff <= pend2_char_in;
      if (wr_en) line_buf[wr_pos] <= wr_char;
      // copy writes the slot in the cycle after the line buffer read
      cp_char_ff <= line_buf[pos_ff];
      cp_addr_ff <= {q_head_ff, pos_ff};
      if (cp_we_ff) slot_text[cp_addr_ff] <= cp_char_ff;
      if (ctl.copy_done) slot_len[q_head_ff] <= line_len_ff;
      rd_char_ff <= slot_text[{rslot_in, pos_in}];
   end

   always_comb begin
      rsp_data.command_ready = rdy_ff;
      rsp_data.command_code = code_ff;
      rsp_data.line_valid = emit_read;
      rsp_data.line_char = (emit_read && rlen_ff != '0) ? rd_char_ff : 8'h00;
      rsp_data.last = emit_read ? sts.read_last : 1'b1;
      rsp_data.line_depth = depth;
      rsp_data.max_line_depth = q_max_ff;
      rsp_data.dropped_lines = drop_l_ff;
      rsp_data.dropped_chars = drop_c_ff;
      rsp_data.shortcut_pending = sc_pending_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      ctl.copy_done |=> q_head_ff != q_tail_ff)
      else $error("enqueue left queue empty");
   assert property (@(posedge clock) disable iff (reset)
      ctl.read_start |-> q_head_ff != q_tail_ff)
      else $error("read from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      q_max_ff >= depth)
      else $error("high-water mark below depth");

endmodule

// ----- hdl/serial_command_line_parser.sv -----
// serial_command_line_parser: top level, config register and block wiring
// depends on scp_pkg, scp_ctrl, scp_datapath
//
// channel   direction  signals
// req       in         req_valid req_ready req_data
// rsp       out        rsp_valid rsp_ready rsp_data
// csr       in/out     psel penable pwrite paddr pwdata prdata pready
//
// a char, tick, poll or take passes through accept, decide and one result beat
// a submitted queue line adds a copy step for each character copied into its slot
// a read returns one beat per character (a single empty beat if none), paced by rsp_ready
// one item in flight; reset is synchronous and needs no clearing pass
module serial_command_line_parser import scp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [DELAY_W-1:0] delay_ff;
   req_type req_ff;
   req_type req_cur;
   ctl_type ctl;
   sts_type sts;
   logic emit_read;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_DELAY) ? {8'h00, delay_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_DELAY) begin
         delay_ff <= csr_pwdata[DELAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req_data;
   end

   assign req_cur = ctl.load ? req_data : req_ff;

   scp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .ctl, .emit_read
   );

   scp_datapath u_dp (
      .clock, .reset, .req_data(req_cur), .ctl, .emit_read, .delay(delay_ff),
      .sts, .rsp_data
   );

endmodule

// ----- tb/serial_command_line_parser_test.sv -----
// serial_command_line_parser_test: self-checking bench for the serial command line parser
// feeds chars, ticks, polls, takes and line reads, predicts every result beat and compares
// depends on scp_pkg and serial_command_line_parser
module serial_command_line_parser_test;
   import scp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [0:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   serial_command_line_parser DUT (.*);

   // parser model state
   logic [DELAY_W-1:0] delay_setting;
   logic [7:0]         edit_buf [LINE_BYTES];
   int                 edit_len;
   bit                 shortcut_held;
   int                 shortcut_letter;
   logic [DELAY_W-1:0] shortcut_ticks;
   bit                 command_held;
   logic [2:0]         held_code;
   logic [7:0]         slot_chars [LINE_SLOTS][LINE_BYTES];
   int                 slot_count [LINE_SLOTS];
   int                 queue_head, queue_tail, queue_peak;
   int                 lines_dropped, chars_dropped;

   rsp_type expected_beats[$];
   req_type pending_items[$];

   int  cycle_count, issued_count, accepted_count, beats_checked;
   int  mismatch_count, settings_used, items_queued;
   int  send_gap, recv_stall;

   function automatic int queue_depth();
      return (queue_head + LINE_SLOTS - queue_tail) % LINE_SLOTS;
   endfunction

   function automatic void expect_beat(bit rdy, logic [2:0] code, bit lv, logic [7:0] ch,
                                       bit lst);
      rsp_type e;
      e.command_ready = rdy;
      e.command_code = code;
      e.line_valid = lv;
      e.line_char = ch;
      e.last = lst;
      e.line_depth = 3'(queue_depth());
      e.max_line_depth = 3'(queue_peak);
      e.dropped_lines = 16'(lines_dropped);
      e.dropped_chars = 16'(chars_dropped);
      e.shortcut_pending = shortcut_held;
      expected_beats.push_back(e);
   endfunction

   function automatic void count_line_drop();
      if (lines_dropped < 65535) lines_dropped++;
   endfunction

   function automatic void add_char(logic [7:0] c);
      if (edit_len >= LINE_BYTES - 1) begin
         if (chars_dropped < 65535) chars_dropped++;
      end else begin
         edit_buf[edit_len] = c;
         edit_len++;
      end
   endfunction

   function automatic void hold_command(logic [2:0] code);
      if (command_held) begin
         count_line_drop();
      end else begin
         held_code = code;
         command_held = 1;
      end
   endfunction

   function automatic bit line_matches(string s);
      if (edit_len != s.len()) return 0;
      for (int i = 0; i < edit_len; i++)
         if (edit_buf[i] != s[i]) return 0;
      return 1;
   endfunction

   function automatic void submit_line();
      int nxt;
      if (edit_len == 0) return;
      if (line_matches("G") || line_matches("START")) begin
         hold_command(CODE_START);
      end else if (line_matches("H") || line_matches("X") || line_matches("HALT") ||
                   line_matches("STOP")) begin
         hold_command(CODE_HALT);
      end else if (line_matches("RESET")) begin
         hold_command(CODE_RESET);
      end else begin
         nxt = (queue_head + 1) % LINE_SLOTS;
         if (nxt == queue_tail) begin
            count_line_drop();
         end else begin
            for (int i = 0; i < edit_len; i++) slot_chars[queue_head][i] = edit_buf[i];
            slot_count[queue_head] = edit_len;
            queue_head = nxt;
            if (queue_depth() > queue_peak) queue_peak = queue_depth();
         end
      end
      edit_len = 0;
   endfunction

   function automatic void flush_shortcut();
      string letters;
      letters = "SHRB";
      if (shortcut_held) begin
         add_char(letters[shortcut_letter]);
         shortcut_held = 0;
      end
   endfunction

   function automatic void receive_char(logic [7:0] c);
      if (c == 8'h0a || c == 8'h0d) begin
         flush_shortcut();
         submit_line();
      end else if (c == 8'h08 || c == 8'h7f) begin
         if (shortcut_held) shortcut_held = 0;
         else if (edit_len > 0) edit_len--;
      end else if (c >= 8'h20 && c <= 8'h7e) begin
         flush_shortcut();
         if (edit_len == 0 && (c == "s" || c == "h" || c == "r" || c == "b")) begin
            shortcut_held = 1;
            shortcut_letter = (c == "s") ? 0 : (c == "h") ? 1 : (c == "r") ? 2 : 3;
            shortcut_ticks = '0;
         end else begin
            if (c >= "a" && c <= "z") c = c - 8'h20;
            add_char(c);
         end
      end
   endfunction

   function automatic bit command_available();
      logic [2:0] codes [4];
      codes = '{CODE_START, CODE_HALT, CODE_RESET, CODE_BATTERY};
      if (command_held) return 1;
      if (!shortcut_held || shortcut_ticks < delay_setting) return 0;
      shortcut_held = 0;
      hold_command(codes[shortcut_letter]);
      return 1;
   endfunction

   function automatic void parse_item(req_type r);
      bit rdy;
      logic [2:0] code;
      int n, slot;
      case (r.command)
         CMD_CHAR: begin
            receive_char(r.char_in);
            expect_beat(0, CODE_NONE, 0, 8'h00, 1);
         end
         CMD_TICK: begin
            if (shortcut_held && shortcut_ticks != ELAPSED_MAX) shortcut_ticks++;
            expect_beat(0, CODE_NONE, 0, 8'h00, 1);
         end
         CMD_POLL: begin
            rdy = command_available();
            expect_beat(rdy, rdy ? held_code : CODE_NONE, 0, 8'h00, 1);
         end
         CMD_TAKE: begin
            rdy = command_available();
            code = rdy ? held_code : CODE_NONE;
            if (rdy) begin
               command_held = 0;
               held_code = CODE_NONE;
            end
            expect_beat(rdy, code, 0, 8'h00, 1);
         end
         CMD_READ: begin
            if (r.read_limit == 0 || queue_head == queue_tail) begin
               expect_beat(0, CODE_NONE, 0, 8'h00, 1);
            end else begin
               slot = queue_tail;
               n = slot_count[slot];
               if (n > LINE_BYTES - 1) n = LINE_BYTES - 1;
               if (n >= r.read_limit) n = r.read_limit - 1;
               queue_tail = (queue_tail + 1) % LINE_SLOTS;
               if (n == 0) expect_beat(0, CODE_NONE, 1, 8'h00, 1);
               for (int i = 0; i < n; i++)
                  expect_beat(0, CODE_NONE, 1, slot_chars[slot][i], i + 1 == n);
            end
         end
         default: expect_beat(0, CODE_NONE, 0, 8'h00, 1);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(negedge clock) begin
      if (!reset && !(req_valid && accepted_count == issued_count)) begin
         if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1;
               issued_count <= issued_count + 1;
               send_gap <= pick_gap();
            end
         end
      end else if (!reset) begin
         if (send_gap == 0 && pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            issued_count <= issued_count + 1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end
      end
      if (!reset) begin
         if (recv_stall > 0) begin
            rsp_ready <= 0;
            recv_stall <= recv_stall - 1;
         end else begin
            rsp_ready <= 1;
            recv_stall <= pick_gap();
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type e;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
                  expected_beats.size());
         $display("serial_command_line_parser test failed");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            parse_item(req_data);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected beat %p", rsp_data);
            end else begin
               e = expected_beats.pop_front();
               beats_checked++;
               if (rsp_data !== e) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("beat %0d mismatch\n  expected %p\n  actual   %p",
                              beats_checked, e, rsp_data);
               end
            end
         end
      end
   end

   task automatic push_item(logic [2:0] cmd, logic [7:0] ch, logic [6:0] lim);
      req_type r;
      r.command = cmd;
      r.char_in = ch;
      r.read_limit = lim;
      pending_items.push_back(r);
      items_queued++;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_item(CMD_CHAR, s[i], 7'd0);
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_delay(logic [DELAY_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= REG_DELAY;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      delay_setting = value;
      settings_used++;
   endtask

   task automatic random_items(int count);
      string words [10];
      string w;
      int stop_at, r, n;
      words = '{"G", "START", "HALT", "STOP", "X", "H", "RESET", "STATUS", "GO", "B"};
      stop_at = items_queued + count;
      while (items_queued < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            if ($urandom_range(0, 1)) begin
               w = words[$urandom_range(0, 9)];
            end else begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 9);
               w = "";
               for (int i = 0; i < n; i++) w = {w, string'(8'($urandom_range(8'h20, 8'h7e)))};
            end
            for (int i = 0; i < w.len(); i++) begin
               if (w[i] >= "A" && w[i] <= "Z" && $urandom_range(0, 1)) w[i] = w[i] + 8'h20;
               push_item(CMD_CHAR, w[i], 7'($urandom));
               if ($urandom_range(0, 19) == 0) push_item(CMD_CHAR, 8'h7f, 7'd0);
            end
            push_item(CMD_CHAR, $urandom_range(0, 1) ? 8'h0d : 8'h0a, 7'd0);
         end else if (r < 55) begin
            w = "shrb";
            push_item(CMD_CHAR, w[$urandom_range(0, 3)], 7'd0);
            n = $urandom_range(0, 7);
            for (int i = 0; i < n; i++) push_item(CMD_TICK, 8'($urandom), 7'($urandom));
            push_item($urandom_range(0, 1) ? CMD_POLL : CMD_TAKE, 8'h00, 7'd0);
         end else if (r < 70) begin
            push_item($urandom_range(0, 1) ? CMD_POLL : CMD_TAKE, 8'($urandom), 7'($urandom));
         end else if (r < 85) begin
            push_item(CMD_READ, 8'($urandom),
                      ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64)));
         end else if (r < 90) begin
            push_item(CMD_TICK, 8'h00, 7'd0);
         end else if (r < 95) begin
            push_item(CMD_CHAR, 8'($urandom), 7'($urandom));
         end else begin
            push_item(3'($urandom_range(5, 7)), 8'($urandom), 7'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      delay_setting = DELAY_RESET;
      edit_len = 0;
      shortcut_held = 0;
      shortcut_letter = 0;
      shortcut_ticks = '0;
      command_held = 0;
      held_code = CODE_NONE;
      queue_head = 0;
      queue_tail = 0;
      queue_peak = 0;
      lines_dropped = 0;
      chars_dropped = 0;
      cycle_count = 0;
      issued_count = 0;
      accepted_count = 0;
      beats_checked = 0;
      mismatch_count = 0;
      settings_used = 0;
      items_queued = 0;
      send_gap = 0;
      recv_stall = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: non-printables, edits, commands, shortcut with reset delay
      push_item(CMD_CHAR, 8'h00, 7'h7f);
      push_item(CMD_CHAR, 8'hff, 7'd0);
      push_item(CMD_CHAR, 8'h80, 7'd0);
      push_text("az ~");
      push_item(CMD_CHAR, 8'h08, 7'd0);
      push_item(CMD_CHAR, 8'h7f, 7'd0);
      push_item(CMD_CHAR, 8'h0d, 7'd0);
      push_item(CMD_CHAR, 8'h0a, 7'd0);
      push_text("g\r");
      push_text("halt\n");
      push_item(CMD_POLL, 8'h00, 7'd0);
      push_item(CMD_TAKE, 8'h00, 7'd0);
      push_text("s");
      push_item(CMD_TICK, 8'h00, 7'd0);
      push_item(CMD_POLL, 8'h00, 7'd0);
      push_text("a\r");
      for (int i = 0; i < 70; i++) push_item(CMD_CHAR, 8'h41 + 8'(i % 26), 7'd0);
      push_text("\r");
      for (int i = 0; i < 8; i++) push_text({"L", string'(8'h30 + 8'(i)), "\r"});
      push_item(CMD_READ, 8'h00, 7'd0);
      push_item(CMD_READ, 8'h00, 7'd1);
      push_item(CMD_READ, 8'h00, 7'd64);
      push_item(CMD_READ, 8'h00, 7'h7f);
      push_item(3'd5, 8'h00, 7'd0);
      push_item(3'd6, 8'h00, 7'd0);
      push_item(3'd7, 8'h00, 7'd0);
      push_text("x\rstop\rreset\rSTART\r");
      push_item(CMD_TAKE, 8'h00, 7'd0);
      push_item(CMD_TAKE, 8'h00, 7'd0);
      wait_idle();

      // zero delay: shortcut promotes immediately
      write_delay('0);
      push_text("h");
      push_item(CMD_POLL, 8'h00, 7'd0);
      push_item(CMD_TAKE, 8'h00, 7'd0);
      push_text("b");
      push_item(CMD_TAKE, 8'h00, 7'd0);
      random_items(8);
      wait_idle();

      write_delay(24'd3);
      random_items(10);
      wait_idle();

      write_delay(ELAPSED_MAX);
      push_text("r");
      push_item(CMD_TICK, 8'h00, 7'd0);
      push_item(CMD_POLL, 8'h00, 7'd0);
      random_items(4);
      wait_idle();

      write_delay(24'd1);
      random_items(4);
      wait_idle();

      $display("ran %0d items over %0d delay settings, %0d result beats checked",
               accepted_count, settings_used + 1, beats_checked);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("serial_command_line_parser test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("serial_command_line_parser test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/scp_pkg.sv
hdl/scp_ctrl.sv
hdl/scp_datapath.sv
hdl/serial_command_line_parser.sv
tb/serial_command_line_parser_test.sv
